>>> design/counted_serial_byte_receiver_assert.svh
// Assertion macros for the counted serial byte receiver checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef COUNTED_SERIAL_BYTE_RECEIVER_ASSERT_SVH
`define COUNTED_SERIAL_BYTE_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CSBR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("csbr assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CSBR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("csbr assertion failed");

`endif

>>> design/csbr_pkg.sv
// Shared types and constants for the counted serial byte receiver.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package csbr_pkg;

    localparam int unsigned DATA_BITS  = 8;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 24;

    // Output field positions in m_tdata
    localparam int unsigned RX_LSB     = 0;
    localparam int unsigned PHASE_LSB  = RX_LSB + BYTE_W;
    localparam int unsigned REM_LSB    = PHASE_LSB + PHASE_W;
    localparam int unsigned PAD_W      = M_TDATA_W - REM_LSB - BYTE_W;

    localparam logic [BYTE_W-1:0]  MSB_MASK      = 8'h80;
    localparam logic [CNT_W-1:0]   BIT_LOAD      = 4'(DATA_BITS);
    localparam logic [BYTE_W-1:0]  BYTE_COUNT_RST = 8'd1;

    localparam logic [PHASE_W-1:0] PHASE_WAIT_CODE = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_DATA_CODE = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_STOP_CODE = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_DONE_CODE = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_ERR_CODE  = 3'd4;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    typedef enum logic [4:0] {
        PH_WAIT = 5'b00001,
        PH_DATA = 5'b00010,
        PH_STOP = 5'b00100,
        PH_DONE = 5'b01000,
        PH_ERR  = 5'b10000
    } phase_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_WAIT: code = PHASE_WAIT_CODE;
            PH_DATA: code = PHASE_DATA_CODE;
            PH_STOP: code = PHASE_STOP_CODE;
            PH_DONE: code = PHASE_DONE_CODE;
            default: code = PHASE_ERR_CODE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> design/counted_serial_byte_receiver.sv
// The result of an accepted request is written into the output register.
// Throughput: one request per cycle while the output is not stalled; the state update is a single registered pass.
// A new request is taken while the held result is being read out (m_tready high).
// Reset (rst_n low, asynchronous): phase wait-start, byte count and bytes left 1,
// output register empty.
`timescale 1ns / 1ps
`default_nettype none

module counted_serial_byte_receiver
    import csbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [BYTE_W-1:0]    cfg_wdata,      // byte_count
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,        // [0] line_level, rest zero
    input  wire logic                 s_tuser,        // [0] mode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,        // [7:0] received_byte,
                                                      // [10:8] phase,
                                                      // [18:11] bytes_remaining
    output logic                      m_tuser         // [0] byte_valid
);

    logic [BYTE_W-1:0]  byte_count_reg;
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic [BYTE_W-1:0]  left_reg, left_next;
    logic               valid_next;
    logic [BYTE_W-1:0]  rx_next;

    logic               m_valid_reg;
    logic               m_user_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic               s_accept;
    logic               line_high;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign line_high = s_tdata[0];

    always_comb
    begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        valid_next   = 1'b0;
        rx_next      = '0;
        if (s_tuser == MODE_RESTART)
        begin
            // reload, saturating a zero count to one
            left_next  = (byte_count_reg == '0) ? BYTE_COUNT_RST : byte_count_reg;
            phase_next = PH_WAIT;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (!line_high)
                    begin
                        phase_next   = PH_DATA;
                        bit_cnt_next = BIT_LOAD;
                        shift_next   = '0;
                    end
                end
                PH_DATA:
                begin
                    shift_next = (shift_reg >> 1) | (line_high ? MSB_MASK : '0);
                    if (bit_cnt_reg <= CNT_W'(1))
                    begin
                        bit_cnt_next = '0;
                        valid_next   = 1'b1;
                        rx_next      = shift_next;
                        if (left_reg != '0)
                        begin
                            left_next = left_reg - BYTE_W'(1);
                        end
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                    end
                end
                PH_STOP:
                begin
                    if (line_high)
                    begin
                        phase_next = (left_reg == '0) ? PH_DONE : PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                default:
                begin
                    // done and error are sticky until a restart
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= BYTE_COUNT_RST;
        end
        else if (cfg_wen)
        begin
            byte_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            left_reg    <= BYTE_COUNT_RST;
        end
        else if (s_accept)
        begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            m_user_reg <= valid_next;
            m_data_reg <= {{PAD_W{1'b0}}, left_next, phase_code(phase_next), rx_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> design/csbr_checker.sv
// Port-level checker for the counted serial byte receiver, bound to the top level.
// Depends on csbr_pkg and counted_serial_byte_receiver_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "counted_serial_byte_receiver_assert.svh"

module csbr_checker
    import csbr_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser
);

    logic [PHASE_W-1:0] phase_w;
    logic [BYTE_W-1:0]  rx_w;
    logic [BYTE_W-1:0]  rem_w;

    assign rx_w    = m_tdata[RX_LSB +: BYTE_W];
    assign phase_w = m_tdata[PHASE_LSB +: PHASE_W];
    assign rem_w   = m_tdata[REM_LSB +: BYTE_W];

    // stalled result holds
    `CSBR_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // an accepted request always leaves a result behind
    `CSBR_ASSERT_NXT(a_result, clk, rst_n, s_tvalid && s_tready, m_tvalid)

    // no byte reported means a zero byte field
    `CSBR_ASSERT_IMP(a_rx_zero, clk, rst_n, m_tvalid && !m_tuser, rx_w == '0)

    // a completed byte always moves to the stop bit
    `CSBR_ASSERT_IMP(a_byte_stop, clk, rst_n, m_tvalid && m_tuser,
        phase_w == PHASE_STOP_CODE)

    // done is reached only with nothing left
    `CSBR_ASSERT_IMP(a_done_empty, clk, rst_n, m_tvalid && (phase_w == PHASE_DONE_CODE),
        rem_w == '0)

endmodule

bind counted_serial_byte_receiver csbr_checker u_csbr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> dv/counted_serial_byte_receiver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for counted_serial_byte_receiver: directed table, then framed random
// line samples under varying back-pressure. Depends on csbr_pkg and the receiver RTL only.

module counted_serial_byte_receiver_tb;
    import csbr_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_STEP = 250;

    typedef struct packed {
        logic                byte_valid;
        logic [BYTE_W-1:0]   rx_byte;
        logic [PHASE_W-1:0]  rx_phase;
        logic [BYTE_W-1:0]   remaining;
    } rx_result_t;

    typedef enum logic { ROW_REQUEST, ROW_COUNT_WRITE } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               mode;
        logic               level;
        logic [BYTE_W-1:0]  count;
        bit                 typed;
        rx_result_t         want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [BYTE_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    // receiver copy of the block state
    logic [PHASE_W-1:0]    rx_phase;
    logic [CNT_W-1:0]      rx_bits_left;
    logic [BYTE_W-1:0]     rx_shift;
    logic [BYTE_W-1:0]     rx_bytes_left;
    logic [BYTE_W-1:0]     byte_count_cfg;

    rx_result_t            rx_results_due[$];
    stim_row_t             stim_table[$];
    int                    fail_count;
    int                    sent_items;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    hold_req;
    int                    hold_left;
    int                    stall_cycles;

    counted_serial_byte_receiver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the receiver by one request and return what it reports
    function automatic rx_result_t rx_next_result(input logic mode, input logic level);
        rx_result_t res;
        res = '0;
        if (mode == MODE_RESTART)
        begin
            rx_bytes_left = (byte_count_cfg == '0) ? 8'd1 : byte_count_cfg;
            rx_phase = PHASE_WAIT_CODE;
        end
        else
        begin
            case (rx_phase)
                PHASE_WAIT_CODE:
                begin
                    if (!level)
                    begin
                        rx_phase = PHASE_DATA_CODE;
                        rx_bits_left = BIT_LOAD;
                        rx_shift = '0;
                    end
                end
                PHASE_DATA_CODE:
                begin
                    rx_shift = (rx_shift >> 1) | (level ? MSB_MASK : '0);
                    if (rx_bits_left <= CNT_W'(1))
                    begin
                        rx_bits_left = '0;
                        res.byte_valid = 1'b1;
                        res.rx_byte = rx_shift;
                        if (rx_bytes_left != '0)
                            rx_bytes_left = rx_bytes_left - BYTE_W'(1);
                        rx_phase = PHASE_STOP_CODE;
                    end
                    else
                        rx_bits_left = rx_bits_left - CNT_W'(1);
                end
                PHASE_STOP_CODE:
                begin
                    if (level)
                        rx_phase = (rx_bytes_left == '0) ? PHASE_DONE_CODE : PHASE_WAIT_CODE;
                    else
                        rx_phase = PHASE_ERR_CODE;
                end
                default:
                begin
                    // done and error hold until a restart
                end
            endcase
        end
        res.rx_phase = rx_phase;
        res.remaining = rx_bytes_left;
        return res;
    endfunction

    function automatic stim_row_t mk_req(input logic mode, input logic level);
        stim_row_t row;
        row = '{ROW_REQUEST, mode, level, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic stim_row_t mk_chk(input logic mode, input logic level, input logic valid,
                                         input logic [BYTE_W-1:0] rx_byte,
                                         input logic [PHASE_W-1:0] ph,
                                         input logic [BYTE_W-1:0] rem);
        stim_row_t row;
        row = '{ROW_REQUEST, mode, level, '0, 1'b1, '{valid, rx_byte, ph, rem}};
        return row;
    endfunction

    function automatic stim_row_t mk_cfg(input logic [BYTE_W-1:0] count);
        stim_row_t row;
        row = '{ROW_COUNT_WRITE, MODE_SAMPLE, 1'b0, count, 1'b0, '0};
        return row;
    endfunction

    // Offer one request; valid stays high on return until the next call or write lowers it
    task automatic send_request(input logic mode, input logic level,
                                input bit typed = 1'b0, input rx_result_t want = '0);
        rx_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_TDATA_W'(level);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (mode == MODE_RESTART ||
            (rx_phase != PHASE_DONE_CODE && rx_phase != PHASE_ERR_CODE))
            sent_items++;
        res = rx_next_result(mode, level);
        rx_results_due.push_back(typed ? want : res);
    endtask

    // Drain everything in flight, then load the byte count register
    task automatic write_byte_count(input logic [BYTE_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rx_results_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        byte_count_cfg = value;
    endtask

    // One framed byte: up to two marks, start, eight data bits, stop (occasionally low)
    task automatic send_frame();
        int unsigned marks;
        logic [BYTE_W-1:0] data;
        marks = $urandom_range(0, 2);
        data  = BYTE_W'($urandom_range(0, 255));
        repeat (marks) send_request(MODE_SAMPLE, 1'b1);
        send_request(MODE_SAMPLE, 1'b0);
        for (int b = 0; b < DATA_BITS; b++)
        begin
            // abort the byte now and then with a restart
            if ($urandom_range(99) == 0)
            begin
                send_request(MODE_RESTART, 1'($urandom_range(0, 1)));
                return;
            end
            send_request(MODE_SAMPLE, data[b]);
        end
        send_request(MODE_SAMPLE, ($urandom_range(99) < 6) ? 1'b0 : 1'b1);
    endtask

    task automatic run_random(input int goal);
        int unsigned pick;
        while (sent_items < goal)
        begin
            pick = $urandom_range(99);
            if ((rx_phase == PHASE_DONE_CODE || rx_phase == PHASE_ERR_CODE) && pick >= 10)
                send_request(MODE_RESTART, 1'($urandom_range(0, 1)));
            else if (pick < 3)
                send_request(MODE_RESTART, 1'($urandom_range(0, 1)));
            else if (pick < 8)
                send_request(MODE_SAMPLE, 1'($urandom_range(0, 1)));
            else
                send_frame();
        end
    endtask

    // Receiver side: random stalls, or a long hold-off when one is requested
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rx_results_due.size() == 0)
            begin
                $error("result with nothing expected: tdata %0h tuser %0b", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = rx_results_due.pop_front();
                if (m_tuser !== want.byte_valid)
                begin
                    $error("byte_valid expected %0h actual %0h", want.byte_valid, m_tuser);
                    fail_count++;
                end
                if (m_tdata[RX_LSB +: BYTE_W] !== want.rx_byte)
                begin
                    $error("received_byte expected %0h actual %0h",
                           want.rx_byte, m_tdata[RX_LSB +: BYTE_W]);
                    fail_count++;
                end
                if (m_tdata[PHASE_LSB +: PHASE_W] !== want.rx_phase)
                begin
                    $error("phase expected %0h actual %0h",
                           want.rx_phase, m_tdata[PHASE_LSB +: PHASE_W]);
                    fail_count++;
                end
                if (m_tdata[REM_LSB +: BYTE_W] !== want.remaining)
                begin
                    $error("bytes_remaining expected %0h actual %0h",
                           want.remaining, m_tdata[REM_LSB +: BYTE_W]);
                    fail_count++;
                end
            end
        end
    end

    // Drop out if neither side moves a request for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wen        = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = MODE_SAMPLE;
        fail_count     = 0;
        sent_items     = 0;
        hold_req       = 0;
        send_idle_pct  = 37;
        recv_idle_pct  = 71;
        rx_phase       = PHASE_WAIT_CODE;
        rx_bits_left   = '0;
        rx_shift       = '0;
        rx_bytes_left  = BYTE_COUNT_RST;
        byte_count_cfg = BYTE_COUNT_RST;

        stim_table = {
            mk_chk(MODE_SAMPLE, 1'b1, 1'b0, 8'h00, PHASE_WAIT_CODE, 8'd1),
            mk_chk(MODE_SAMPLE, 1'b0, 1'b0, 8'h00, PHASE_DATA_CODE, 8'd1),
            mk_req(MODE_SAMPLE, 1'b1), mk_req(MODE_SAMPLE, 1'b1), mk_req(MODE_SAMPLE, 1'b1),
            mk_req(MODE_SAMPLE, 1'b1), mk_req(MODE_SAMPLE, 1'b1), mk_req(MODE_SAMPLE, 1'b1),
            mk_req(MODE_SAMPLE, 1'b1),
            mk_chk(MODE_SAMPLE, 1'b1, 1'b1, 8'hFF, PHASE_STOP_CODE, 8'd0),
            mk_chk(MODE_SAMPLE, 1'b1, 1'b0, 8'h00, PHASE_DONE_CODE, 8'd0),
            mk_req(MODE_SAMPLE, 1'b0),
            mk_cfg(8'd255),
            mk_chk(MODE_RESTART, 1'b0, 1'b0, 8'h00, PHASE_WAIT_CODE, 8'd255),
            mk_req(MODE_SAMPLE, 1'b0),
            mk_req(MODE_SAMPLE, 1'b0), mk_req(MODE_SAMPLE, 1'b0), mk_req(MODE_SAMPLE, 1'b0),
            mk_req(MODE_SAMPLE, 1'b0), mk_req(MODE_SAMPLE, 1'b0), mk_req(MODE_SAMPLE, 1'b0),
            mk_req(MODE_SAMPLE, 1'b0),
            mk_chk(MODE_SAMPLE, 1'b0, 1'b1, 8'h00, PHASE_STOP_CODE, 8'd254),
            mk_chk(MODE_SAMPLE, 1'b0, 1'b0, 8'h00, PHASE_ERR_CODE, 8'd254),
            mk_req(MODE_SAMPLE, 1'b1),
            // a zero count saturates to one on reload
            mk_cfg(8'd0),
            mk_chk(MODE_RESTART, 1'b1, 1'b0, 8'h00, PHASE_WAIT_CODE, 8'd1)
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_COUNT_WRITE)
                write_byte_count(stim_table[i].count);
            else
                send_request(stim_table[i].mode, stim_table[i].level,
                             stim_table[i].typed, stim_table[i].want);
        end

        sent_items = 0;
        for (int step = 0; step < 6; step++)
        begin
            case (step / 2)
                0:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 71;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_idle_pct = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (step % 2 == 1)
                write_byte_count(BYTE_W'($urandom_range(2, 8)));
            else
                write_byte_count((step == 2) ? 8'd255 : 8'd1);
            // hold the output while requests keep coming so the input backs up
            if (step == 4)
                hold_req = 400;
            send_request(MODE_RESTART, 1'($urandom_range(0, 1)));
            run_random((step + 1) * ITEMS_PER_STEP);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rx_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
